// ===== rtl/cdls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdls_pkg
// Shared types and constants of the charlieplex display list scanner.
// ----------------------------------------------------------------------------
package cdls_pkg;

    // LED number that marks the end of the display list
    localparam logic [7:0] END_MARK = 8'd255;

    // item operation codes
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // pin drive state of the shown slot
    typedef struct packed {
        logic       led_on;
        logic [3:0] set_pin;
        logic [3:0] sink_pin;
        logic [6:0] shown_entry;
    } t_drive;

    // one result word
    typedef struct packed {
        t_drive drive;
        logic   slot_start;
    } t_result;

endpackage

// ===== rtl/charlieplex_display_list_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// charlieplex_display_list_scanner_core
// Display list scanner for a charlieplexed LED matrix. The list lives in two
// synchronous memories; the entry at the scan index and the LED number of the
// entry after it are read ahead from the next scan index so that a tick can
// start a slot at once.
// A result word is registered in the output register, or in the skid stage
// while the output stalls. Throughput: one item per cycle while o_stall is
// low; the list read for the next slot is issued in the same cycle that the
// scan index updates; write data is forwarded. Reset clears scan state and
// drive pins; a pass then fills the list with end markers, o_stall held high.
// ----------------------------------------------------------------------------
module charlieplex_display_list_scanner_core #(
    parameter int PIN_COUNT  = 16,
    parameter int LED_COUNT  = 240,
    parameter int LIST_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [6:0]  i_entry_index,
    input  logic [7:0]  i_led_number,
    input  logic [23:0] i_dwell_ticks,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_led_on,
    output logic [3:0]  o_set_pin,
    output logic [3:0]  o_sink_pin,
    output logic [6:0]  o_shown_entry,
    output logic        o_slot_start
);

    localparam int IW     = $clog2(LIST_DEPTH);
    localparam int PIN_M1 = PIN_COUNT - 1;
    // reciprocal constants, exact for every 8-bit LED number
    localparam int SP_SH  = 8 + $clog2(PIN_COUNT);
    localparam int SP_MUL = ((1 << SP_SH) + PIN_COUNT - 1) / PIN_COUNT;
    localparam int RP_SH  = 8 + $clog2(PIN_M1);
    localparam int RP_MUL = ((1 << RP_SH) + PIN_M1 - 1) / PIN_M1;

    // display list memories
    logic [7:0]  r_led_mem   [LIST_DEPTH];
    logic [23:0] r_dwell_mem [LIST_DEPTH];

    // scan state
    logic [IW-1:0]        r_scan, n_scan;
    logic [23:0]          r_ticks, n_ticks;
    cdls_pkg::t_drive     r_drive, n_drive;

    // clearing pass
    logic                 r_clearing;
    logic [IW-1:0]        r_clr_addr;

    // prefetched list data for r_scan and r_scan + 1
    logic [7:0]           r_qa_led;
    logic [23:0]          r_qa_dwell;
    logic [7:0]           r_qb_led;
    logic                 r_qb_last;
    logic                 qb_end;

    // memory port signals
    logic                 w_en;
    logic [IW-1:0]        w_addr;
    logic [7:0]           w_led;
    logic [23:0]          w_dwell;
    logic [IW-1:0]        addr_a, addr_b;
    logic                 b_last;

    // pin number arithmetic
    logic [31:0]          sp_prod, rp_prod;
    logic [7:0]           sp_quot, rp_quot;

    // item handling
    logic                 acc, is_tick, is_wr, start, led_ok;
    logic [IW+6:0]        idx_ext;
    cdls_pkg::t_result    res;

    // output register and skid stage
    cdls_pkg::t_result    r_out, r_skid;
    logic                 r_out_valid, r_skid_valid;
    logic                 out_take;

    assign acc     = i_valid && !o_stall;
    assign is_tick = acc && (i_operation == cdls_pkg::OP_TICK);
    assign is_wr   = acc && (i_operation == cdls_pkg::OP_WRITE);
    assign start   = is_tick && (r_ticks == 24'd0);
    assign qb_end  = r_qb_last || (r_qb_led == cdls_pkg::END_MARK);
    assign led_ok  = 32'(r_qa_led) < LED_COUNT;
    assign idx_ext = {7'd0, r_scan};

    // divide the LED number by the pin counts with reciprocal multiplies
    assign sp_prod = 32'(r_qa_led) * 32'(SP_MUL);
    assign sp_quot = 8'(sp_prod >> SP_SH);
    assign rp_prod = 32'(r_qa_led) * 32'(RP_MUL);
    assign rp_quot = 8'(rp_prod >> RP_SH);

    // next scan state
    always_comb begin
        n_scan  = r_scan;
        n_ticks = r_ticks;
        n_drive = r_drive;
        if (start) begin
            n_drive.shown_entry = idx_ext[6:0];
            if (led_ok) begin
                n_drive.led_on    = 1'b1;
                n_drive.set_pin   = 4'(32'(r_qa_led) - 32'(sp_quot) * 32'(PIN_COUNT));
                n_drive.sink_pin  = 4'(32'(PIN_M1) - 32'(rp_quot));
            end else begin
                n_drive.led_on    = 1'b0;
                n_drive.set_pin   = 4'd0;
                n_drive.sink_pin  = 4'd0;
            end
            // zero dwell counts as one tick
            n_ticks = (r_qa_dwell == 24'd0) ? 24'd0 : r_qa_dwell - 24'd1;
            n_scan  = qb_end ? '0 : r_scan + 1'b1;
        end else if (is_tick) begin
            n_ticks = r_ticks - 24'd1;
        end
        res.drive      = n_drive;
        res.slot_start = start;
    end

    // write port: clearing pass or list write
    always_comb begin
        if (r_clearing) begin
            w_en    = 1'b1;
            w_addr  = r_clr_addr;
            w_led   = cdls_pkg::END_MARK;
            w_dwell = 24'd0;
        end else begin
            w_en    = is_wr && (32'(i_entry_index) < LIST_DEPTH);
            w_addr  = IW'(i_entry_index);
            w_led   = i_led_number;
            w_dwell = i_dwell_ticks;
        end
    end

    // read addresses follow the scan index of the next cycle
    assign addr_a = n_scan;
    assign b_last = (n_scan == IW'(LIST_DEPTH - 1));
    assign addr_b = n_scan + 1'b1;

    // list memories: write, read with same-cycle write forwarding
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_led_mem[w_addr]   <= w_led;
            r_dwell_mem[w_addr] <= w_dwell;
        end
        r_qa_led   <= (w_en && w_addr == addr_a) ? w_led   : r_led_mem[addr_a];
        r_qa_dwell <= (w_en && w_addr == addr_a) ? w_dwell : r_dwell_mem[addr_a];
        r_qb_led   <= (w_en && w_addr == addr_b) ? w_led   : r_led_mem[addr_b];
        r_qb_last  <= b_last;
    end

    // scan state and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= '0;
            r_ticks    <= 24'd0;
            r_drive    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_scan  <= n_scan;
            r_ticks <= n_ticks;
            r_drive <= n_drive;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(LIST_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // output register with skid stage
    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!r_out_valid || out_take) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (acc) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall       = r_skid_valid || r_clearing;
    assign o_valid       = r_out_valid;
    assign o_led_on      = r_out.drive.led_on;
    assign o_set_pin     = r_out.drive.set_pin;
    assign o_sink_pin    = r_out.drive.sink_pin;
    assign o_shown_entry = r_out.drive.shown_entry;
    assign o_slot_start  = r_out.slot_start;

endmodule
